### rtl/erf_pkg.sv
package erf_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int TYPE_W        = 3;
    localparam int ARG_W         = 32;
    localparam int STAMP_W       = 64;
    localparam int CNT_W_DEFAULT = $clog2(DEPTH_DEFAULT + 1);

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_DRAIN = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_READ,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic [TYPE_W-1:0]        ev_type;
        logic signed [ARG_W-1:0]  arg_first;
        logic signed [ARG_W-1:0]  arg_second;
        logic [STAMP_W-1:0]       stamp;
    } t_rec;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic do_push;
        logic do_pop;
        logic drain_step;
        logic load_out;
    } t_dp_ctl;

    // datapath -> controller
    typedef struct packed {
        t_cmd cmd;
        logic empty;
        logic full;
        logic out_busy;
    } t_dp_sts;

endpackage

### rtl/erf_in_if.sv
interface erf_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           cmd;
    logic [erf_pkg::TYPE_W-1:0]           event_type;
    logic signed [erf_pkg::ARG_W-1:0]     arg_first;
    logic signed [erf_pkg::ARG_W-1:0]     arg_second;
    logic [erf_pkg::STAMP_W-1:0]          stamp;
    logic [erf_pkg::TYPE_W-1:0]           wanted_type;

    modport source (
        output valid, cmd, event_type, arg_first, arg_second, stamp, wanted_type,
        input  ready
    );
    modport sink (
        input  valid, cmd, event_type, arg_first, arg_second, stamp, wanted_type,
        output ready
    );
endinterface

### rtl/erf_out_if.sv
interface erf_out_if #(
    parameter int CntW = erf_pkg::CNT_W_DEFAULT
);
    logic                                 valid;
    logic                                 ready;
    logic                                 ok;
    logic [erf_pkg::TYPE_W-1:0]           out_type;
    logic signed [erf_pkg::ARG_W-1:0]     out_arg_first;
    logic signed [erf_pkg::ARG_W-1:0]     out_arg_second;
    logic [erf_pkg::STAMP_W-1:0]          out_stamp;
    logic [CntW-1:0]                      fill_count;
    logic                                 is_full;
    logic [CntW-1:0]                      match_count;

    modport source (
        output valid, ok, out_type, out_arg_first, out_arg_second, out_stamp,
               fill_count, is_full, match_count,
        input  ready
    );
    modport sink (
        input  valid, ok, out_type, out_arg_first, out_arg_second, out_stamp,
               fill_count, is_full, match_count,
        output ready
    );
endinterface

### rtl/event_ring_fifo_unit.sv
// Channel  Dir  Modport          Payload
// i_in     in   erf_in_if.sink   cmd, event_type, arg_first, arg_second, stamp, wanted_type
// o_out    out  erf_out_if.source ok, out_type, out_arg_first, out_arg_second, out_stamp,
//                                fill_count, is_full, match_count
//
// Push, pop and peek have an accept step and one execute step in which the result
// register loads; no new transaction is accepted until the execute step is done.
// Drain walks the queue through the single memory read port, one slot a cycle,
// and then loads the result register.
// Reset (i_rst_n low, synchronous) clears the pointers, the state and o_out.valid.
// A stalled o_out holds the finished result; the next transaction is still accepted
// and its execute step waits until the result register frees.
module event_ring_fifo_unit #(
    parameter int DEPTH = erf_pkg::DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    erf_in_if.sink     i_in,
    erf_out_if.source  o_out
);
    import erf_pkg::*;

    t_dp_ctl ctl;
    t_dp_sts sts;
    logic    in_ready;

    // Controller: sequences each transaction, sees only handshake, command and status.
    erf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (t_cmd'(i_in.cmd)),
        .o_in_ready (in_ready),
        .o_ctl      (ctl),
        .i_sts      (sts)
    );

    // Datapath: pointers, record memory, match counter and result register.
    erf_dpath #(
        .Depth (DEPTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

    assign i_in.ready = in_ready;

endmodule

### rtl/erf_ctrl.sv
module erf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  erf_pkg::t_cmd    i_in_cmd,
    output logic             o_in_ready,
    output erf_pkg::t_dp_ctl o_ctl,
    input  erf_pkg::t_dp_sts i_sts
);
    import erf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_cmd)
                        CMD_PUSH:            n_state = ST_PUSH;
                        CMD_POP, CMD_PEEK:   n_state = ST_READ;
                        CMD_DRAIN:           n_state = ST_DRAIN;
                        default:             n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PUSH, ST_READ: begin
                if (!i_sts.out_busy) n_state = ST_IDLE;
            end
            ST_DRAIN: begin
                if (i_sts.empty && !i_sts.out_busy) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_ctl      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_ctl.capture = i_in_valid;
            end
            ST_PUSH: begin
                o_ctl.load_out = !i_sts.out_busy;
                o_ctl.do_push  = !i_sts.out_busy && !i_sts.full;
            end
            ST_READ: begin
                o_ctl.load_out = !i_sts.out_busy;
                o_ctl.do_pop   = !i_sts.out_busy && !i_sts.empty && (i_sts.cmd == CMD_POP);
            end
            ST_DRAIN: begin
                o_ctl.drain_step = !i_sts.empty;
                o_ctl.load_out   = i_sts.empty && !i_sts.out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/erf_dpath.sv
module erf_dpath #(
    parameter int Depth = erf_pkg::DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  erf_pkg::t_dp_ctl i_ctl,
    output erf_pkg::t_dp_sts o_sts,
    erf_in_if.sink           i_in,
    erf_out_if.source        o_out
);
    import erf_pkg::*;

    localparam int AW   = $clog2(Depth);
    localparam int PW   = $clog2(2 * Depth);
    localparam int CW   = $clog2(Depth + 1);
    localparam logic [PW-1:0] DEPTH_P   = PW'(Depth);
    localparam logic [PW-1:0] PTR_LAST  = PW'(2 * Depth - 1);
    localparam logic [PW:0]   SPAN_X    = (PW + 1)'(2 * Depth);
    localparam logic [CW-1:0] DEPTH_C   = CW'(Depth);

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_of(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = (p >= DEPTH_P) ? p - DEPTH_P : p;
        return s[AW-1:0];
    endfunction

    function automatic logic [CW-1:0] level(input logic [PW-1:0] w, input logic [PW-1:0] r);
        logic [PW:0] t;
        t = {1'b0, w} - {1'b0, r};
        if (w < r) t = t + SPAN_X;
        return t[CW-1:0];
    endfunction

    // captured transaction
    t_cmd               r_cmd;
    t_rec               r_rec_in;
    logic [TYPE_W-1:0]  r_want;

    logic [PW-1:0]      r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]      r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]      r_match;
    logic [CW-1:0]      fill_now, fill_after;

    t_rec               mem [Depth];
    t_rec               r_rd_data;

    logic               r_out_valid;
    logic               r_ok;
    t_rec               r_out_rec;
    logic [CW-1:0]      r_fill;
    logic               r_full;
    logic [CW-1:0]      r_out_match;

    logic               res_ok;
    t_rec               res_rec;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd               <= t_cmd'(i_in.cmd);
            r_rec_in.ev_type    <= i_in.event_type;
            r_rec_in.arg_first  <= i_in.arg_first;
            r_rec_in.arg_second <= i_in.arg_second;
            r_rec_in.stamp      <= i_in.stamp;
            r_want              <= i_in.wanted_type;
        end
    end

    assign fill_now   = level(r_wr_ptr, r_rd_ptr);
    assign n_wr_ptr   = i_ctl.do_push ? ptr_next(r_wr_ptr) : r_wr_ptr;
    assign n_rd_ptr   = (i_ctl.do_pop || i_ctl.drain_step) ? ptr_next(r_rd_ptr) : r_rd_ptr;
    assign fill_after = level(n_wr_ptr, n_rd_ptr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    // read follows the next head slot, so the head record is registered together with the read pointer
    always_ff @(posedge i_clk) begin
        if (i_ctl.do_push) begin
            mem[slot_of(r_wr_ptr)] <= r_rec_in;
        end
        r_rd_data <= mem[slot_of(n_rd_ptr)];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_match <= '0;
        end else if (i_ctl.drain_step && (r_rd_data.ev_type == r_want)) begin
            r_match <= r_match + CW'(1);
        end
    end

    always_comb begin
        res_ok  = 1'b0;
        res_rec = '0;
        case (r_cmd)
            CMD_PUSH:  res_ok = (fill_now != DEPTH_C);
            CMD_POP, CMD_PEEK: begin
                res_ok = (fill_now != '0);
                if (res_ok) res_rec = r_rd_data;
            end
            default:   res_ok = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_ok        <= res_ok;
            r_out_rec   <= res_rec;
            r_fill      <= fill_after;
            r_full      <= (fill_after == DEPTH_C);
            r_out_match <= (r_cmd == CMD_DRAIN) ? r_match : '0;
        end
    end

    assign o_sts.cmd      = r_cmd;
    assign o_sts.empty    = (fill_now == '0);
    assign o_sts.full     = (fill_now == DEPTH_C);
    assign o_sts.out_busy = r_out_valid && !o_out.ready;

    assign o_out.valid          = r_out_valid;
    assign o_out.ok             = r_ok;
    assign o_out.out_type       = r_out_rec.ev_type;
    assign o_out.out_arg_first  = r_out_rec.arg_first;
    assign o_out.out_arg_second = r_out_rec.arg_second;
    assign o_out.out_stamp      = r_out_rec.stamp;
    assign o_out.fill_count     = r_fill;
    assign o_out.is_full        = r_full;
    assign o_out.match_count    = r_out_match;

endmodule
